// ===== src/gtpe_pkg.sv =====
// Shared types, constants and glyph font functions for the glyph text pixel emitter.
// Used by the controller, the datapath and the top level; depends on nothing else.
package gtpe_pkg;

   // Glyph cell geometry and cursor limits.
   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 7;
   localparam logic [6:0] GLYPH_MASK = 7'h7F;
   localparam logic signed [11:0] GLYPH_ADVANCE = 12'sd6;
   localparam logic signed [11:0] CURSOR_MAX = 12'sd2047;
   localparam logic signed [11:0] CURSOR_SAT_LIMIT = CURSOR_MAX - GLYPH_ADVANCE;
   localparam logic [8:0] MAX_DIM = 9'd320;

   // Scan position codes.
   localparam logic [2:0] COL_LAST = 3'(GLYPH_COLS - 1);
   localparam logic [2:0] ROW_LAST = 3'(GLYPH_ROWS - 1);

   // Configuration register indexes.
   localparam logic [1:0] REG_VIEW_WIDTH = 2'd0;
   localparam logic [1:0] REG_VIEW_HEIGHT = 2'd1;

   // One glyph: five columns of seven rows, bit r of a column is row r.
   typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // take a new character and reset the scan
      logic step;   // advance the scan position by one bit
      logic take;   // current pixel goes to the holding slot, older one to the output
      logic flush;  // holding slot goes to the output as the final pixel
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cand;        // current bit is lit and inside the viewport
      logic scan_end;    // scan sits on the last bit of the cell
      logic pend_valid;  // holding slot holds a pixel
      logic out_free;    // output register can take a word this cycle
   } stat_type;

   // Map a character code onto its font row; unknown codes use the blank glyph.
   function automatic logic [4:0] char_index(input logic [7:0] code);
      logic [4:0] idx;
      idx = 5'd0;
      if (code >= 8'h30 && code <= 8'h39) begin
         idx = 5'd5 + code[4:0] - 5'd16;
      end else begin
         case (code)
            8'h3A: idx = 5'd1;   // colon
            8'h2E: idx = 5'd2;   // dot
            8'h25: idx = 5'd3;   // percent
            8'h2D: idx = 5'd4;   // dash
            8'h43: idx = 5'd15;  // C
            8'h48: idx = 5'd16;  // H
            8'h4D: idx = 5'd17;  // M
            8'h50: idx = 5'd18;  // P
            8'h52: idx = 5'd19;  // R
            8'h54: idx = 5'd20;  // T
            8'h45: idx = 5'd21;  // E
            default: idx = 5'd0;
         endcase
      end
      return idx;
   endfunction

   // Build a glyph from five column bytes, column 0 first.
   function automatic glyph_type mk_glyph(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [7:0] b4);
      glyph_type g;
      g[0] = b0[6:0] & GLYPH_MASK;
      g[1] = b1[6:0] & GLYPH_MASK;
      g[2] = b2[6:0] & GLYPH_MASK;
      g[3] = b3[6:0] & GLYPH_MASK;
      g[4] = b4[6:0] & GLYPH_MASK;
      return g;
   endfunction

   // Font ROM of 22 glyphs.
   function automatic glyph_type glyph_rom(input logic [4:0] idx);
      glyph_type g;
      case (idx)
         5'd1:  g = mk_glyph(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
         5'd2:  g = mk_glyph(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
         5'd3:  g = mk_glyph(8'h62, 8'h64, 8'h08, 8'h13, 8'h23);
         5'd4:  g = mk_glyph(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
         5'd5:  g = mk_glyph(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
         5'd6:  g = mk_glyph(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
         5'd7:  g = mk_glyph(8'h62, 8'h51, 8'h49, 8'h49, 8'h46);
         5'd8:  g = mk_glyph(8'h22, 8'h49, 8'h49, 8'h49, 8'h36);
         5'd9:  g = mk_glyph(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
         5'd10: g = mk_glyph(8'h2F, 8'h49, 8'h49, 8'h49, 8'h31);
         5'd11: g = mk_glyph(8'h3E, 8'h49, 8'h49, 8'h49, 8'h32);
         5'd12: g = mk_glyph(8'h01, 8'h01, 8'h79, 8'h05, 8'h03);
         5'd13: g = mk_glyph(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
         5'd14: g = mk_glyph(8'h26, 8'h49, 8'h49, 8'h49, 8'h3E);
         5'd15: g = mk_glyph(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
         5'd16: g = mk_glyph(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
         5'd17: g = mk_glyph(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
         5'd18: g = mk_glyph(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
         5'd19: g = mk_glyph(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
         5'd20: g = mk_glyph(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
         5'd21: g = mk_glyph(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
         default: g = mk_glyph(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      endcase
      return g;
   endfunction

endpackage

// ===== src/gtpe_ctrl.sv =====
// Controller state machine of the glyph text pixel emitter.
// Sequences load, bit scan and final flush; uses gtpe_pkg command and status types.
module gtpe_ctrl
   import gtpe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // A visible pixel that would push an older one out waits for the output.
            if (!(stat.cand && stat.pend_valid && !stat.out_free)) begin
               cmd.step = 1'b1;
               cmd.take = stat.cand;
               if (stat.scan_end) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/gtpe_dp.sv =====
// Datapath of the glyph text pixel emitter: viewport registers, cursor, glyph
// scan position, one-pixel holding slot and output register. Uses gtpe_pkg.
module gtpe_dp
   import gtpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Character word fields
   input  logic [7:0]  char_code,
   input  logic        first_char,
   input  logic [11:0] start_x,
   input  logic [11:0] start_y,
   input  logic [15:0] ink_color,
   // Register writes
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data,
   // Controller link
   input  cmd_type     cmd,
   output stat_type    stat,
   // Pixel word
   input  logic        rsp_tready,
   output logic        rsp_valid,
   output logic [8:0]  pixel_x,
   output logic [8:0]  pixel_y,
   output logic [15:0] pixel_color,
   output logic        last_pixel
);

   logic [8:0]         width_ff;
   logic [8:0]         height_ff;
   logic [8:0]         dim_clamped;
   logic signed [11:0] cursor_col_ff;
   logic signed [11:0] cursor_col_in;
   logic signed [11:0] cursor_row_ff;
   logic signed [11:0] cursor_row_in;
   logic signed [11:0] base_col_ff;
   logic signed [11:0] base_row_ff;
   logic signed [11:0] load_col;
   logic signed [11:0] load_row;
   glyph_type          glyph_ff;
   logic [15:0]        color_ff;
   logic [2:0]         col_ff;
   logic [2:0]         row_ff;
   logic signed [12:0] px;
   logic signed [12:0] py;
   logic               visible;
   logic               pend_valid_ff;
   logic [8:0]         pend_x_ff;
   logic [8:0]         pend_y_ff;
   logic               out_valid_ff;
   logic [8:0]         out_x_ff;
   logic [8:0]         out_y_ff;
   logic [15:0]        out_color_ff;
   logic               out_last_ff;
   logic               out_free;

   // Viewport registers hold the clamped dimension.
   assign dim_clamped = (csr_data > MAX_DIM) ? MAX_DIM : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd320;
         height_ff <= 9'd240;
      end else if (csr_write) begin
         if (csr_index == REG_VIEW_WIDTH) begin
            width_ff <= dim_clamped;
         end else if (csr_index == REG_VIEW_HEIGHT) begin
            height_ff <= dim_clamped;
         end
      end
   end

   // Cell origin for the new character and the cursor advance after it.
   always_comb begin
      load_col      = first_char ? $signed(start_x) : cursor_col_ff;
      load_row      = first_char ? $signed(start_y) : cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (cmd.load) begin
         cursor_row_in = load_row;
         cursor_col_in = (load_col > CURSOR_SAT_LIMIT) ? CURSOR_MAX : load_col + GLYPH_ADVANCE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

   // Character payload captured at load.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_col_ff <= load_col;
         base_row_ff <= load_row;
         glyph_ff    <= glyph_rom(char_index(char_code));
         color_ff    <= ink_color;
      end
   end

   // Scan position: rows inside columns.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.load) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.step) begin
         if (row_ff == ROW_LAST) begin
            row_ff <= '0;
            col_ff <= col_ff + 3'd1;
         end else begin
            row_ff <= row_ff + 3'd1;
         end
      end
   end

   // Pixel position of the current bit and its viewport test.
   assign px = 13'(base_col_ff) + 13'(col_ff);
   assign py = 13'(base_row_ff) + 13'(row_ff);
   assign visible = !px[12] && (px[11:0] < {3'b000, width_ff})
                 && !py[12] && (py[11:0] < {3'b000, height_ff});

   assign out_free = !out_valid_ff || rsp_tready;

   assign stat.cand       = glyph_ff[col_ff][row_ff] && visible;
   assign stat.scan_end   = (col_ff == COL_LAST) && (row_ff == ROW_LAST);
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   // Holding slot keeps the newest pixel until it is known whether it is the last.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.take) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pend_x_ff <= px[8:0];
         pend_y_ff <= py[8:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if ((cmd.take && pend_valid_ff) || cmd.flush) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.take && pend_valid_ff) || cmd.flush) begin
         out_x_ff     <= pend_x_ff;
         out_y_ff     <= pend_y_ff;
         out_color_ff <= color_ff;
         out_last_ff  <= cmd.flush;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign pixel_x     = out_x_ff;
   assign pixel_y     = out_y_ff;
   assign pixel_color = out_color_ff;
   assign last_pixel  = out_last_ff;

endmodule

// ===== src/glyph_text_pixel_emitter.sv =====
// Glyph text pixel emitter: one character word in, one word per visible lit pixel out.
// Per character: load, then 35 glyph bits at one per cycle while the output takes every
// word (an output stall can hold the scan), then flush; a new character waits for idle.
// Reset: synchronous; cursor to (0,0), viewport 320 x 240, no word pending.
// Top level; instantiates gtpe_ctrl and gtpe_dp, uses gtpe_pkg.
module glyph_text_pixel_emitter
   import gtpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Character words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // char_code[7:0], start_x[19:8], start_y[31:20],
                                   // ink_color[47:32]
   input  logic        req_tuser,  // first_char
   // Pixel words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // pixel_x[8:0], pixel_y[17:9], pixel_color[33:18],
                                   // zero[39:34]
   output logic        rsp_tlast,  // last_pixel
   // Register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);

   cmd_type     cmd;
   stat_type    stat;
   logic [8:0]  pixel_x;
   logic [8:0]  pixel_y;
   logic [15:0] pixel_color;

   assign csr_ready = 1'b1;

   gtpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gtpe_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .char_code   (req_tdata[7:0]),
      .first_char  (req_tuser),
      .start_x     (req_tdata[19:8]),
      .start_y     (req_tdata[31:20]),
      .ink_color   (req_tdata[47:32]),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .pixel_color (pixel_color),
      .last_pixel  (rsp_tlast)
   );

   // Pack the pixel word.
   assign rsp_tdata = {6'b000000, pixel_color, pixel_y, pixel_x};

endmodule

// ===== src/gtpe_checker.sv =====
// Port-level checker for the glyph text pixel emitter, bound to the top level.
// Depends on glyph_text_pixel_emitter port names only.
module gtpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled pixel word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("pixel word dropped while stalled");

   // A stalled pixel word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("pixel word changed while stalled");

   // Pixels lie inside the largest viewport and the padding stays zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8:0] < 9'd320) && (rsp_tdata[17:9] < 9'd320)
                     && (rsp_tdata[39:34] == 6'd0))
      else $error("pixel word out of range");

   // One character at a time: no new word right after one is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("character accepted during scan");

endmodule

bind glyph_text_pixel_emitter gtpe_checker u_gtpe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
